### rtl/kmd_pkg.sv
// Package for the key matrix debounce block: sizes, tdata layout, lane structs.
// No dependencies; used by every module of the block.
`default_nettype none

package kmd_pkg;

	// matrix geometry
	localparam int ROWS      = 8;
	localparam int COLS      = 16;
	localparam int COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;

	// field widths fixed by the interface
	localparam int COL_W   = 4;
	localparam int LVL_W   = 8;
	localparam int STAMP_W = 32;
	localparam int DEB_W   = 16;

	localparam logic [DEB_W-1:0] DEB_RESET = 16'd5;

	// slave tdata: column | row_levels | now_ms, padded to bytes
	localparam int S_COL_LO  = 0;
	localparam int S_LVL_LO  = S_COL_LO + COL_W;
	localparam int S_NOW_LO  = S_LVL_LO + LVL_W;
	localparam int S_USED_W  = S_NOW_LO + STAMP_W;
	localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

	// master tdata: column_out | debounced_levels | changed_mask, padded to bytes
	localparam int M_COL_LO  = 0;
	localparam int M_DEB_LO  = M_COL_LO + COL_W;
	localparam int M_CHG_LO  = M_DEB_LO + LVL_W;
	localparam int M_USED_W  = M_CHG_LO + LVL_W;
	localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

	// one accepted request, broadcast to every row lane
	typedef struct packed {
		logic                 take;
		logic                 col_ok;
		logic [COL_W-1:0]     column;
		logic [COL_IDX_W-1:0] col_idx;
		logic [STAMP_W-1:0]   now;
		logic [DEB_W-1:0]     deb_time;
	} step_t;

	// what one lane found for the strobed key
	typedef struct packed {
		logic stable;
		logic changed;
	} lane_res_t;

endpackage

`default_nettype wire

### rtl/kmd_lane.sv
// One row lane: raw sample, change stamp and debounced level for every column of a row.
// Depends on kmd_pkg.
`default_nettype none

module kmd_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kmd_pkg::step_t    step,
	input  wire logic              raw,
	output kmd_pkg::lane_res_t     res
);

	logic                          last_q   [kmd_pkg::COLS];
	logic [kmd_pkg::STAMP_W-1:0]   stamp_q  [kmd_pkg::COLS];
	logic                          stable_q [kmd_pkg::COLS];

	logic                          cur_last;
	logic [kmd_pkg::STAMP_W-1:0]   cur_stamp;
	logic                          cur_stable;
	logic                          raw_edge;
	logic [kmd_pkg::STAMP_W-1:0]   elapsed;
	logic                          settled;
	logic                          new_stable;
	logic                          hit;

	assign cur_last   = last_q[step.col_idx];
	assign cur_stamp  = stamp_q[step.col_idx];
	assign cur_stable = stable_q[step.col_idx];

	// a fresh edge restarts the timer, so the key cannot settle in that step
	assign raw_edge   = raw != cur_last;
	assign elapsed    = step.now - cur_stamp;
	assign settled    = !raw_edge &&
		(elapsed > {{(kmd_pkg::STAMP_W-kmd_pkg::DEB_W){1'b0}}, step.deb_time});
	assign new_stable = settled ? raw : cur_stable;
	assign hit        = step.take && step.col_ok;

	assign res.stable  = step.col_ok && new_stable;
	assign res.changed = step.col_ok && settled && (cur_stable != raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < kmd_pkg::COLS; c++) begin
				last_q[c]   <= 1'b0;
				stamp_q[c]  <= '0;
				stable_q[c] <= 1'b0;
			end
		end else if (hit) begin
			last_q[step.col_idx]   <= raw;
			stable_q[step.col_idx] <= new_stable;
			if (raw_edge) begin
				stamp_q[step.col_idx] <= step.now;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/kmd_merge.sv
// Merge stage: gathers lane results into the row masks and holds the output register.
// Depends on kmd_pkg.
`default_nettype none

module kmd_merge (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kmd_pkg::step_t                    step,
	input  wire kmd_pkg::lane_res_t                res [kmd_pkg::ROWS],
	input  wire logic                              m_tready,
	output logic                                   m_tvalid,
	output logic [kmd_pkg::M_TDATA_W-1:0]          m_tdata,
	output logic                                   s_tready
);

	logic [kmd_pkg::LVL_W-1:0] deb_mask;
	logic [kmd_pkg::LVL_W-1:0] chg_mask;
	logic                      m_valid_q;
	logic [kmd_pkg::COL_W-1:0] col_q;
	logic [kmd_pkg::LVL_W-1:0] deb_q;
	logic [kmd_pkg::LVL_W-1:0] chg_q;

	// mask bits beyond the lane count read as zero; lanes beyond the output width are dropped
	for (genvar r = 0; r < kmd_pkg::LVL_W; r++) begin : g_bit
		if (r < kmd_pkg::ROWS) begin : g_lane
			assign deb_mask[r] = res[r].stable;
			assign chg_mask[r] = res[r].changed;
		end else begin : g_pad
			assign deb_mask[r] = 1'b0;
			assign chg_mask[r] = 1'b0;
		end
	end

	assign s_tready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= step.take;
		end
	end

	always_ff @(posedge clk) begin
		if (step.take && s_tready) begin
			col_q <= step.column;
			deb_q <= deb_mask;
			chg_q <= chg_mask;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(kmd_pkg::M_TDATA_W-kmd_pkg::M_USED_W){1'b0}}, chg_q, deb_q, col_q};

endmodule

`default_nettype wire

### rtl/key_matrix_debounce_top.sv
// Top level of the key matrix debounce block: config register, row lanes, merge stage.
// Depends on kmd_pkg, kmd_lane, kmd_merge.
//
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata) carries one request per strobed
//    column: the column index, the raw level of each row and the ms timestamp.
//  - Master stream (m_tvalid/m_tready/m_tdata) returns exactly one result per
//    request: the column echoed, the debounced row levels, and a mask of the
//    rows whose debounced level changed with this request.
//  - cfg_valid/cfg_ready/cfg_data write the debounce time in ms (reset 5).
//    cfg_ready is always high; write only while no request is in flight.
//  - Output: the result is in the output register in the cycle after accept.
//  - Throughput: one request per cycle unless a stalled result holds s_tready
//    low. Each row has its own lane holding that row's state for all columns,
//    so a column's read-modify-write of stamp and levels finishes inside the
//    accepting cycle and the next request, even to the same column, sees the update.
//  - Stall: when the receiver holds m_tready low with a result waiting,
//    s_tready drops in the same cycle; nothing is lost or repeated.
//  - Reset: arst_n clears all key state (raw, stamp, debounced level) at once,
//    empties the output register and reloads the debounce time. No sweep.
`default_nettype none

module key_matrix_debounce_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [3:0] column, [11:4] row_levels, [43:12] now_ms, [47:44] zero
	input  wire logic [kmd_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [3:0] column_out, [11:4] debounced_levels, [19:12] changed_mask, [23:20] zero
	output logic [kmd_pkg::M_TDATA_W-1:0]          m_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [kmd_pkg::DEB_W-1:0]         cfg_data
);

	logic [kmd_pkg::DEB_W-1:0] deb_time_q;
	kmd_pkg::step_t            step;
	kmd_pkg::lane_res_t        res [kmd_pkg::ROWS];
	logic [kmd_pkg::LVL_W-1:0] row_levels;

	// debounce time register; always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_time_q <= kmd_pkg::DEB_RESET;
		end else if (cfg_valid) begin
			deb_time_q <= cfg_data;
		end
	end

	// unpack the request and broadcast it to the lanes
	assign row_levels    = s_tdata[kmd_pkg::S_LVL_LO +: kmd_pkg::LVL_W];
	assign step.take     = s_tvalid && s_tready;
	assign step.column   = s_tdata[kmd_pkg::S_COL_LO +: kmd_pkg::COL_W];
	// columns past the matrix leave state alone and report zero masks
	assign step.col_ok   = 32'(step.column) < kmd_pkg::COLS;
	assign step.col_idx  = kmd_pkg::COL_IDX_W'(step.column);
	assign step.now      = s_tdata[kmd_pkg::S_NOW_LO +: kmd_pkg::STAMP_W];
	assign step.deb_time = deb_time_q;

	for (genvar r = 0; r < kmd_pkg::ROWS; r++) begin : g_row
		logic raw;
		// rows past the input width sense a constant low
		if (r < kmd_pkg::LVL_W) begin : g_in
			assign raw = row_levels[r];
		end else begin : g_low
			assign raw = 1'b0;
		end

		kmd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.raw    (raw),
			.res    (res[r])
		);
	end

	kmd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.s_tready (s_tready)
	);

endmodule

`default_nettype wire

### rtl/kmd_checker.sv
// Port-level checks for the key matrix debounce top; bound to it below.
// Depends on kmd_pkg and key_matrix_debounce_top.
`default_nettype none

module kmd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [kmd_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [kmd_pkg::M_TDATA_W-1:0] m_tdata
);

	// each accepted request shows a result the next cycle
	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request produced no result");

	// the result carries the column of the request it came from
	a_col_echo: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=>
		m_tdata[kmd_pkg::M_COL_LO +: kmd_pkg::COL_W] ==
		$past(s_tdata[kmd_pkg::S_COL_LO +: kmd_pkg::COL_W]))
		else $error("result column does not match request");

	// a waiting result blocks new requests
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while result stalled");

	// a taken result with no new request leaves the output empty
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result appeared without a request");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind key_matrix_debounce_top kmd_checker u_kmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### sim/key_matrix_debounce_top_tb.sv
// Self-checking testbench for key_matrix_debounce_top: directed scans, then random column scans.
// Depends on kmd_pkg and the block's RTL; predicts untyped results from its own copy of key state.
`timescale 1ns / 100ps

module key_matrix_debounce_top_tb;
	import kmd_pkg::*;

	// cycles with no accepted request on any channel before the run is declared hung
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_SCANS = 200;
	localparam int HOLD_CYCLES = 48;

	// one result as the master stream carries it
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [LVL_W-1:0] levels;
		logic [LVL_W-1:0] changed;
	} scan_res_t;

	// directed rows: either a column scan or a new debounce time
	typedef enum logic [0:0] {DIR_SCAN, DIR_DEBOUNCE} dir_kind_e;

	typedef struct {
		dir_kind_e          kind;
		logic [COL_W-1:0]   column;
		logic [LVL_W-1:0]   levels;
		logic [STAMP_W-1:0] now_ms;
		logic [DEB_W-1:0]   deb_ms;
		logic               typed;       // expected result given below, not predicted
		logic [LVL_W-1:0]   exp_levels;
		logic [LVL_W-1:0]   exp_changed;
	} dir_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 m_tready  = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [DEB_W-1:0]     cfg_data  = '0;
	wire logic                 s_tready;
	wire logic                 m_tvalid;
	wire logic [M_TDATA_W-1:0] m_tdata;
	wire logic                 cfg_ready;

	key_matrix_debounce_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		// [3:0] column, [11:4] row_levels, [43:12] now_ms, [47:44] zero
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		// [3:0] column_out, [11:4] debounced_levels, [19:12] changed_mask, [23:20] zero
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted key state, one entry per key, row-major
	logic               key_raw   [ROWS][COLS];
	logic [STAMP_W-1:0] key_stamp [ROWS][COLS];
	logic               key_level [ROWS][COLS];
	logic [DEB_W-1:0]   deb_ms;

	scan_res_t expected_scans [$];

	int mismatches   = 0;
	int n_scans      = 0;
	int n_directed   = 0;
	int n_results    = 0;
	int n_changes    = 0;
	int n_deb_writes = 0;
	int hold_reqs    = 0;  // bumped by the sender, served by the receiver
	int holds_served = 0;
	int stall_left   = 0;
	int idle_cycles  = 0;
	bit quiet        = 1'b0;  // no idling on either side

	// Directed scans. Debounce time is the reset value 5 until the first DEBOUNCE row.
	dir_row_t dir_rows [24] = '{
		// reset state reads back all zero
		'{DIR_SCAN,     4'd0,  8'h00, 32'h0000_0000, 16'd0,     1'b1, 8'h00, 8'h00},
		// a level change is never accepted in the step that sees it
		'{DIR_SCAN,     4'd15, 8'hFF, 32'd100,       16'd0,     1'b1, 8'h00, 8'h00},
		// elapsed equal to the debounce time is not enough
		'{DIR_SCAN,     4'd15, 8'hFF, 32'd105,       16'd0,     1'b1, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd15, 8'hFF, 32'd106,       16'd0,     1'b1, 8'hFF, 8'hFF},
		'{DIR_SCAN,     4'd15, 8'hFF, 32'd107,       16'd0,     1'b1, 8'hFF, 8'h00},
		'{DIR_SCAN,     4'd15, 8'h00, 32'd108,       16'd0,     1'b1, 8'hFF, 8'h00},
		'{DIR_SCAN,     4'd15, 8'h00, 32'd200,       16'd0,     1'b1, 8'h00, 8'hFF},
		// elapsed time across the 2^32 wrap
		'{DIR_SCAN,     4'd3,  8'hAA, 32'hFFFF_FFFE, 16'd0,     1'b1, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd3,  8'hAA, 32'h0000_0004, 16'd0,     1'b1, 8'hAA, 8'hAA},
		'{DIR_SCAN,     4'd3,  8'h55, 32'd5,         16'd0,     1'b1, 8'hAA, 8'h00},
		'{DIR_SCAN,     4'd3,  8'h55, 32'd8,         16'd0,     1'b0, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd3,  8'h55, 32'd11,        16'd0,     1'b1, 8'h55, 8'hFF},
		'{DIR_SCAN,     4'd7,  8'h01, 32'hFFFF_FFFF, 16'd0,     1'b0, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd7,  8'h01, 32'h8000_0000, 16'd0,     1'b0, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd8,  8'h80, 32'h7FFF_FFFF, 16'd0,     1'b0, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd8,  8'h7F, 32'h0000_0000, 16'd0,     1'b0, 8'h00, 8'h00},
		// zero debounce: still not in the changing step, accepted one ms later
		'{DIR_DEBOUNCE, 4'd0,  8'h00, 32'd0,         16'd0,     1'b0, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd12, 8'h0F, 32'd50,        16'd0,     1'b1, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd12, 8'h0F, 32'd50,        16'd0,     1'b1, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd12, 8'h0F, 32'd51,        16'd0,     1'b1, 8'h0F, 8'h0F},
		// longest debounce time
		'{DIR_DEBOUNCE, 4'd0,  8'h00, 32'd0,         16'hFFFF,  1'b0, 8'h00, 8'h00},
		'{DIR_SCAN,     4'd12, 8'hF0, 32'd1000,      16'd0,     1'b1, 8'h0F, 8'h00},
		'{DIR_SCAN,     4'd12, 8'hF0, 32'd66535,     16'd0,     1'b1, 8'h0F, 8'h00},
		'{DIR_SCAN,     4'd12, 8'hF0, 32'd66536,     16'd0,     1'b1, 8'hF0, 8'hFF}
	};

	function automatic void clear_keys();
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				key_raw[r][c]   = 1'b0;
				key_stamp[r][c] = '0;
				key_level[r][c] = 1'b0;
			end
		end
		deb_ms = DEB_RESET;
	endfunction

	// One column scan: restamp keys whose raw level moved, then accept levels that
	// have been stable for strictly longer than the debounce time.
	function automatic scan_res_t debounce_column(input logic [COL_W-1:0] col,
			input logic [LVL_W-1:0] lvl, input logic [STAMP_W-1:0] now);
		scan_res_t          res;
		logic               raw;
		logic [STAMP_W-1:0] elapsed;
		res.column  = col;
		res.levels  = '0;
		res.changed = '0;
		if (col < COLS) begin
			for (int r = 0; r < ROWS; r++) begin
				raw = (r < LVL_W) ? lvl[r] : 1'b0;
				if (key_raw[r][col] != raw)
					key_stamp[r][col] = now;
				key_raw[r][col] = raw;
				elapsed = now - key_stamp[r][col];
				if (elapsed > STAMP_W'(deb_ms) && key_level[r][col] != raw) begin
					key_level[r][col] = raw;
					if (r < LVL_W)
						res.changed[r] = 1'b1;
				end
				if (r < LVL_W && key_level[r][col])
					res.levels[r] = 1'b1;
			end
		end
		return res;
	endfunction

	// Offer one request and hold it until accepted; s_tvalid stays high afterwards.
	task automatic send_scan(input logic [COL_W-1:0] col, input logic [LVL_W-1:0] lvl,
			input logic [STAMP_W-1:0] now, input logic typed,
			input logic [LVL_W-1:0] t_levels, input logic [LVL_W-1:0] t_changed);
		logic [S_TDATA_W-1:0] word;
		scan_res_t            res;
		word = '0;
		word[S_COL_LO +: COL_W]   = col;
		word[S_LVL_LO +: LVL_W]   = lvl;
		word[S_NOW_LO +: STAMP_W] = now;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		res = debounce_column(col, lvl, now);
		if (typed) begin
			res.levels  = t_levels;
			res.changed = t_changed;
		end
		expected_scans.push_back(res);
		n_scans++;
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_scans.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_debounce(input logic [DEB_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		deb_ms = value;
		cfg_valid <= 1'b0;
		n_deb_writes++;
	endtask

	// Mostly a column sequencer with a steadily advancing ms clock, bouncing rows
	// and occasional key presses; about one request in seven is pure noise.
	task automatic run_scan_phase(input logic [DEB_W-1:0] deb, input int phase);
		logic [LVL_W-1:0]   col_target [COLS];
		logic [STAMP_W-1:0] clock_ms;
		logic [COL_W-1:0]   scan_col;
		logic [COL_W-1:0]   col;
		logic [LVL_W-1:0]   lvl;
		int                 max_step;
		for (int c = 0; c < COLS; c++)
			col_target[c] = LVL_W'($urandom_range(0, 255));
		// odd phases start just below the wrap
		clock_ms = (phase % 2 == 1) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom();
		max_step = int'(deb) / 8 + 2;
		scan_col = '0;
		write_debounce(deb);
		for (int n = 0; n < PHASE_SCANS; n++) begin
			if (phase == 1 && n == 40)
				hold_reqs++;          // receiver backs off, input side must stall
			if (phase == 2 && n == 100)
				drain_results();      // sender pause until all results are back
			if ($urandom_range(0, 6) == 0) begin
				send_scan(COL_W'($urandom_range(0, 15)), LVL_W'($urandom_range(0, 255)),
					$urandom(), 1'b0, '0, '0);
			end else begin
				col = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(0, 15)) : scan_col;
				scan_col = col + 1'b1;
				if ($urandom_range(0, 15) == 0)
					col_target[col] ^= LVL_W'($urandom_range(1, 255));
				lvl = col_target[col];
				if ($urandom_range(0, 3) == 0)
					lvl ^= LVL_W'($urandom_range(0, 255) & $urandom_range(0, 255));
				clock_ms += STAMP_W'($urandom_range(0, max_step));
				send_scan(col, lvl, clock_ms, 1'b0, '0, '0);
			end
			sender_gap();
		end
	endtask

	// Receiver: check at the edge that accepts, then pick the next m_tready.
	always @(posedge clk) begin
		scan_res_t       got;
		scan_res_t       want;
		logic [M_TDATA_W-1:0] pad;
		if (m_tvalid && m_tready) begin
			got.column  = m_tdata[M_COL_LO +: COL_W];
			got.levels  = m_tdata[M_DEB_LO +: LVL_W];
			got.changed = m_tdata[M_CHG_LO +: LVL_W];
			pad         = m_tdata >> M_USED_W;
			n_results++;
			if (got.changed != '0)
				n_changes++;
			if (expected_scans.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result col %0d with no request outstanding",
						$realtime, got.column);
			end else begin
				want = expected_scans.pop_front();
				if (got.column !== want.column || got.levels !== want.levels ||
						got.changed !== want.changed || pad !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: col %0d: expected deb %h chg %h, got col %0d deb %h chg %h pad %h",
							$realtime, want.column, want.levels, want.changed,
							got.column, got.levels, got.changed, pad);
				end
			end
		end
		if (holds_served < hold_reqs) begin
			holds_served++;
			stall_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (quiet) begin
			stall_left = 0;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: any accepted request on any channel restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no request accepted for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [DEB_W-1:0] deb_plan [7];
		deb_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd20, 16'd0, DEB_RESET, 16'd300};
		deb_plan[4] = DEB_W'($urandom_range(0, 65535));
		clear_keys();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == DIR_DEBOUNCE) begin
				write_debounce(dir_rows[i].deb_ms);
			end else begin
				send_scan(dir_rows[i].column, dir_rows[i].levels, dir_rows[i].now_ms,
					dir_rows[i].typed, dir_rows[i].exp_levels, dir_rows[i].exp_changed);
				sender_gap();
			end
		end
		n_directed = n_scans;

		for (int p = 0; p < 7; p++) begin
			if (p == 6)
				quiet = 1'b1;   // last phase runs flat out on both sides
			run_scan_phase(deb_plan[p], p);
		end

		drain_results();
		repeat (4) @(posedge clk);
		$display("Ran %0d column scans (%0d directed), %0d results checked, %0d with key changes",
			n_scans, n_directed, n_results, n_changes);
		$display("Debounce time written %0d times, from 0 to 65535, with wrap and stall cases",
			n_deb_writes);
		if (mismatches == 0 && expected_scans.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_scans.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
